@@ rtl/core/cheat_code_patch_engine_macros.svh @@
// Assertion macros for the cheat code patch engine RTL.
`ifndef CHEAT_CODE_PATCH_ENGINE_MACROS_SVH
`define CHEAT_CODE_PATCH_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define CCPE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define CCPE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CCPE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CCPE_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/ccpe_pkg.sv @@
// Types, code constants and decode helpers for the cheat code patch engine.
package ccpe_pkg;

   localparam int MAX_CHEATS = 64;
   localparam int MAX_CODES  = 256;
   localparam int CHEAT_W    = $clog2(MAX_CHEATS);
   localparam int CODE_W     = $clog2(MAX_CODES);

   // Code types (top byte of the code word)
   localparam logic [7:0] TYPE_W8        = 8'h80;
   localparam logic [7:0] TYPE_W8_BTN    = 8'h88;
   localparam logic [7:0] TYPE_W8_ALT    = 8'hA0;
   localparam logic [7:0] TYPE_W8_ALTBTN = 8'hA8;
   localparam logic [7:0] TYPE_W8_BOOT   = 8'hF0;
   localparam logic [7:0] TYPE_W16        = 8'h81;
   localparam logic [7:0] TYPE_W16_BTN    = 8'h89;
   localparam logic [7:0] TYPE_W16_ALT    = 8'hA1;
   localparam logic [7:0] TYPE_W16_ALTBTN = 8'hA9;
   localparam logic [7:0] TYPE_W16_BOOT   = 8'hF1;
   localparam logic [7:0] TYPE_EQ8       = 8'hD0;
   localparam logic [7:0] TYPE_EQ8_BTN   = 8'hD8;
   localparam logic [7:0] TYPE_EQ16      = 8'hD1;
   localparam logic [7:0] TYPE_EQ16_BTN  = 8'hD9;
   localparam logic [7:0] TYPE_NE8       = 8'hD2;
   localparam logic [7:0] TYPE_NE8_BTN   = 8'hDB;
   localparam logic [7:0] TYPE_NE16      = 8'hD3;
   localparam logic [7:0] TYPE_NE16_BTN  = 8'hDA;
   localparam logic [7:0] TYPE_SPECIAL   = 8'hEE;

   localparam logic [3:0] NIB_TEST = 4'hD;
   localparam logic [3:0] NIB_BOOT = 4'hF;

   // Fixed writes of the special code
   localparam logic [23:0] SPECIAL_ADDR0 = 24'h000318;
   localparam logic [15:0] SPECIAL_DATA0 = 16'h0040;
   localparam logic [23:0] SPECIAL_ADDR1 = 24'h00031A;
   localparam logic [15:0] SPECIAL_DATA1 = 16'h0000;

   typedef struct packed {
      logic              frame;
      logic [CHEAT_W-1:0] cheat_slot;
      logic              enabled;
      logic              first;
      logic [CODE_W-1:0] code_slot;
      logic [31:0]       code_address;
      logic [15:0]       code_value;
      logic              button;
      logic [15:0]       mem_data;
   } item_type;

   typedef struct packed {
      logic        write_valid;
      logic [23:0] write_address;
      logic [15:0] write_data;
      logic        write_size;
      logic        last_result;
   } result_type;

   typedef struct packed {
      logic              en;
      logic [CODE_W-1:0] addr;
      logic [15:0]       data;
   } store_wr_type;

   function automatic logic test_pass(input logic [7:0] code_type,
                                      input logic [15:0] value,
                                      input logic [15:0] mem);
      logic eq8;
      logic eq16;
      logic pass;
      eq8  = (mem[7:0] == value[7:0]);
      eq16 = (mem == value);
      unique case (code_type) inside
         TYPE_EQ8, TYPE_EQ8_BTN:   pass = eq8;
         TYPE_EQ16, TYPE_EQ16_BTN: pass = eq16;
         TYPE_NE8, TYPE_NE8_BTN:   pass = !eq8;
         TYPE_NE16, TYPE_NE16_BTN: pass = !eq16;
         default:                  pass = 1'b1;
      endcase
      return pass;
   endfunction

   function automatic logic is_button_test(input logic [7:0] code_type);
      return (code_type == TYPE_EQ8_BTN) || (code_type == TYPE_EQ16_BTN) ||
             (code_type == TYPE_NE16_BTN) || (code_type == TYPE_NE8_BTN);
   endfunction

   function automatic logic is_button_write(input logic [7:0] code_type);
      return (code_type == TYPE_W8_BTN) || (code_type == TYPE_W16_BTN) ||
             (code_type == TYPE_W8_ALTBTN) || (code_type == TYPE_W16_ALTBTN);
   endfunction

endpackage

@@ rtl/core/cheat_code_patch_engine.sv @@
// Cheat code patch engine: decodes one code per beat into memory write beats.
// The req beat is registered in the execute stage, and its result beats in the output register.
// Throughput: one code per cycle while rsp_stall does not hold the output register;
// a special two-write code holds the execute stage for both result beats through the single output register.
// Reset (synchronous): clears flags, was-enabled and captured bits at once;
// the saved old-value memory is not cleared and needs no clearing pass.
`include "cheat_code_patch_engine_macros.svh"
module cheat_code_patch_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [ccpe_pkg::CHEAT_W-1:0]  req_cheat_slot,
   input  logic                          req_cheat_enabled,
   input  logic                          req_first_code,
   input  logic [ccpe_pkg::CODE_W-1:0]   req_code_slot,
   input  logic [31:0]                   req_code_address,
   input  logic [15:0]                   req_code_value,
   input  logic                          req_button_pressed,
   input  logic [15:0]                   req_mem_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_write_valid,
   output logic [23:0]                   rsp_write_address,
   output logic [15:0]                   rsp_write_data,
   output logic                          rsp_write_size,
   output logic                          rsp_last_result
);

   // Execute stage
   logic                                 s1_valid_ff, s1_valid_in;
   ccpe_pkg::item_type                   s1_ff;
   logic                                 phase_ff, phase_in;
   // Output register
   logic                                 rsp_valid_ff, rsp_valid_in;
   ccpe_pkg::result_type                 rsp_ff, rsp_in;
   // Engine state
   logic                                 cond_failed_ff, cond_failed_in;
   logic                                 restoring_ff, restoring_in;
   logic [ccpe_pkg::MAX_CHEATS-1:0]      was_enabled_ff, was_enabled_in;
   logic [ccpe_pkg::MAX_CODES-1:0]       captured_ff, captured_in;

   ccpe_pkg::store_wr_type               store_wr;
   logic [15:0]                          store_rd_data;

   logic                                 accept;
   logic                                 out_free;
   logic                                 emit;
   logic                                 retire;

   logic [7:0]                           code_type;
   logic [3:0]                           code_nib;
   logic                                 cap_cur;
   logic                                 cf0;
   logic                                 rc_eff;
   logic                                 cf_new;
   logic                                 rc_new;
   logic                                 we_set;
   logic                                 we_clr;
   logic                                 cap_clr;
   logic                                 run;
   logic                                 allow_save;
   logic [15:0]                          operand;
   logic [1:0]                           res_count;
   logic                                 res_size;
   logic                                 res_special;
   logic                                 save;
   ccpe_pkg::result_type                 res;

   ccpe_saved_store u_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_code_slot),
      .wr      (store_wr),
      .rd_data (store_rd_data)
   );

   // Decode and execute the code held in the execute stage
   always_comb begin
      code_type  = s1_ff.code_address[31:24];
      code_nib   = s1_ff.code_address[31:28];
      cap_cur    = captured_ff[s1_ff.code_slot];
      cf0        = cond_failed_ff;
      rc_eff     = restoring_ff;
      cf_new     = cond_failed_ff;
      rc_new     = restoring_ff;
      we_set     = 1'b0;
      we_clr     = 1'b0;
      cap_clr    = 1'b0;
      run        = 1'b0;
      allow_save = 1'b0;
      operand    = s1_ff.code_value;

      if (s1_ff.enabled) begin
         we_set = 1'b1;
         if (!s1_ff.frame) begin
            run        = (code_nib == ccpe_pkg::NIB_BOOT);
            allow_save = 1'b1;
         end else begin
            cf0    = s1_ff.first ? 1'b0 : cond_failed_ff;
            cf_new = cf0;
            if (code_nib == ccpe_pkg::NIB_TEST) begin
               cf_new = cf0
                  | (ccpe_pkg::is_button_test(code_type) & !s1_ff.button)
                  | !ccpe_pkg::test_pass(code_type, s1_ff.code_value, s1_ff.mem_data);
            end else if (cf0) begin
               // skip this code, drop the flag
               cf_new = 1'b0;
            end else if (ccpe_pkg::is_button_write(code_type)) begin
               run = s1_ff.button;
            end else if (code_nib != ccpe_pkg::NIB_BOOT) begin
               run        = 1'b1;
               allow_save = 1'b1;
            end
         end
      end else begin
         if (s1_ff.first) begin
            rc_eff = was_enabled_ff[s1_ff.cheat_slot] && s1_ff.frame;
            we_clr = 1'b1;
         end
         rc_new = rc_eff;
         if (rc_eff && cap_cur) begin
            run     = 1'b1;
            operand = store_rd_data;
            cap_clr = 1'b1;
         end
      end

      res_size    = 1'b0;
      res_special = 1'b0;
      res_count   = 2'd0;
      case (code_type) inside
         ccpe_pkg::TYPE_W8, ccpe_pkg::TYPE_W8_BTN, ccpe_pkg::TYPE_W8_ALT,
         ccpe_pkg::TYPE_W8_ALTBTN, ccpe_pkg::TYPE_W8_BOOT: begin
            res_count = 2'd1;
         end
         ccpe_pkg::TYPE_W16, ccpe_pkg::TYPE_W16_BTN, ccpe_pkg::TYPE_W16_ALT,
         ccpe_pkg::TYPE_W16_ALTBTN, ccpe_pkg::TYPE_W16_BOOT: begin
            res_count = 2'd1;
            res_size  = 1'b1;
         end
         ccpe_pkg::TYPE_SPECIAL: begin
            res_count   = 2'd2;
            res_size    = 1'b1;
            res_special = 1'b1;
         end
         default: res_count = 2'd0;
      endcase
      if (!run) begin
         res_count = 2'd0;
      end

      save = run && allow_save && !cap_cur && !res_special && (res_count != 2'd0);

      res.write_valid = 1'b1;
      res.write_size  = res_size;
      res.last_result = (res_count == 2'd2) ? phase_ff : 1'b1;
      if (res_special) begin
         res.write_address = phase_ff ? ccpe_pkg::SPECIAL_ADDR1 : ccpe_pkg::SPECIAL_ADDR0;
         res.write_data    = phase_ff ? ccpe_pkg::SPECIAL_DATA1 : ccpe_pkg::SPECIAL_DATA0;
      end else begin
         res.write_address = s1_ff.code_address[23:0];
         res.write_data    = res_size ? operand : {8'h00, operand[7:0]};
      end
   end

   // Handshake and stage control
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      emit      = s1_valid_ff && (res_count != 2'd0) && out_free;
      retire    = s1_valid_ff && ((res_count == 2'd0) ||
                  (out_free && ((res_count == 2'd1) || phase_ff)));
      req_stall = s1_valid_ff && !retire;
      accept    = req_valid && !req_stall;

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (retire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (retire) begin
         phase_in = 1'b0;
      end else if (emit) begin
         phase_in = 1'b1;
      end else begin
         phase_in = phase_ff;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_in = emit ? res : rsp_ff;

      cond_failed_in = cond_failed_ff;
      restoring_in   = restoring_ff;
      was_enabled_in = was_enabled_ff;
      captured_in    = captured_ff;
      if (retire) begin
         cond_failed_in = cf_new;
         restoring_in   = rc_new;
         if (we_set) begin
            was_enabled_in[s1_ff.cheat_slot] = 1'b1;
         end else if (we_clr) begin
            was_enabled_in[s1_ff.cheat_slot] = 1'b0;
         end
         if (save) begin
            captured_in[s1_ff.code_slot] = 1'b1;
         end else if (cap_clr) begin
            captured_in[s1_ff.code_slot] = 1'b0;
         end
      end

      store_wr.en   = retire && save;
      store_wr.addr = s1_ff.code_slot;
      store_wr.data = res_size ? s1_ff.mem_data : {8'h00, s1_ff.mem_data[7:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         phase_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cond_failed_ff <= 1'b0;
         restoring_ff   <= 1'b0;
         was_enabled_ff <= '0;
         captured_ff    <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
         cond_failed_ff <= cond_failed_in;
         restoring_ff   <= restoring_in;
         was_enabled_ff <= was_enabled_in;
         captured_ff    <= captured_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff.frame        <= req_action;
         s1_ff.cheat_slot   <= req_cheat_slot;
         s1_ff.enabled      <= req_cheat_enabled;
         s1_ff.first        <= req_first_code;
         s1_ff.code_slot    <= req_code_slot;
         s1_ff.code_address <= req_code_address;
         s1_ff.code_value   <= req_code_value;
         s1_ff.button       <= req_button_pressed;
         s1_ff.mem_data     <= req_mem_data;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_valid   = rsp_ff.write_valid;
   assign rsp_write_address = rsp_ff.write_address;
   assign rsp_write_data    = rsp_ff.write_data;
   assign rsp_write_size    = rsp_ff.write_size;
   assign rsp_last_result   = rsp_ff.last_result;

   `CCPE_ASSERT_IMP(a_phase_needs_item, clock, reset, phase_ff, s1_valid_ff, "stray phase")
   `CCPE_ASSERT_NXT(a_accept_fills_stage, clock, reset, accept, s1_valid_ff, "no fill")
   `CCPE_ASSERT_IMP(a_phase_not_last, clock, reset, phase_ff, !rsp_ff.last_result, "early last")
   `CCPE_ASSERT_IMP(a_save_uncaptured, clock, reset, store_wr.en, !cap_cur, "resave")

endmodule

@@ rtl/core/ccpe_saved_store.sv @@
// Saved old-value store: one write port, registered read with write forwarding.
module ccpe_saved_store (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [ccpe_pkg::CODE_W-1:0]   rd_addr,
   input  ccpe_pkg::store_wr_type        wr,
   output logic [15:0]                   rd_data
);

   logic [15:0] mem_ff [ccpe_pkg::MAX_CODES];
   logic [15:0] rdata_ff;
   logic        fwd_hit_ff;
   logic [15:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Catch a write landing on the entry read in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff    <= mem_ff[rd_addr];
         fwd_hit_ff  <= wr.en && (wr.addr == rd_addr);
         fwd_data_ff <= wr.data;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rdata_ff;

endmodule

@@ test/cheat_code_patch_engine_checker.sv @@
// Checker for the cheat code patch engine: predicts write beats and compares them.
`timescale 1ns / 1ps
module cheat_code_patch_engine_checker
   import ccpe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_action,
   input  logic [CHEAT_W-1:0] req_cheat_slot,
   input  logic               req_cheat_enabled,
   input  logic               req_first_code,
   input  logic [CODE_W-1:0]  req_code_slot,
   input  logic [31:0]        req_code_address,
   input  logic [15:0]        req_code_value,
   input  logic               req_button_pressed,
   input  logic [15:0]        req_mem_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_write_valid,
   input  logic [23:0]        rsp_write_address,
   input  logic [15:0]        rsp_write_data,
   input  logic               rsp_write_size,
   input  logic               rsp_last_result,
   output int                 mismatches,
   output int                 writes_outstanding
);

   logic        skip_next;
   logic        restoring;
   logic        cheat_was_on [MAX_CHEATS];
   logic [15:0] saved_word [MAX_CODES];
   logic        captured [MAX_CODES];
   result_type  expected_writes [$];

   function automatic logic test_holds(input logic [7:0] ty, input logic [15:0] value,
                                       input logic [15:0] mem);
      logic eq8;
      logic eq16;
      eq8  = (mem[7:0] == value[7:0]);
      eq16 = (mem == value);
      case (ty) inside
         TYPE_EQ8, TYPE_EQ8_BTN:   return eq8;
         TYPE_EQ16, TYPE_EQ16_BTN: return eq16;
         TYPE_NE8, TYPE_NE8_BTN:   return !eq8;
         TYPE_NE16, TYPE_NE16_BTN: return !eq16;
         default:                  return 1'b1;
      endcase
   endfunction

   // Queue the write beats of one write-type code; save the prior memory value if asked.
   task automatic queue_write(input logic [7:0] ty, input logic [23:0] addr,
                              input logic [15:0] value, input logic [15:0] mem,
                              input logic save, input logic [CODE_W-1:0] slot);
      result_type w;
      w = '0;
      w.write_valid = 1'b1;
      case (ty) inside
         TYPE_W8, TYPE_W8_BTN, TYPE_W8_ALT, TYPE_W8_ALTBTN, TYPE_W8_BOOT: begin
            if (save && !captured[slot]) begin
               saved_word[slot] = {8'h00, mem[7:0]};
               captured[slot]   = 1'b1;
            end
            w.write_address = addr;
            w.write_data    = {8'h00, value[7:0]};
            w.write_size    = 1'b0;
            expected_writes.push_back(w);
         end
         TYPE_W16, TYPE_W16_BTN, TYPE_W16_ALT, TYPE_W16_ALTBTN, TYPE_W16_BOOT: begin
            if (save && !captured[slot]) begin
               saved_word[slot] = mem;
               captured[slot]   = 1'b1;
            end
            w.write_address = addr;
            w.write_data    = value;
            w.write_size    = 1'b1;
            expected_writes.push_back(w);
         end
         TYPE_SPECIAL: begin
            w.write_size    = 1'b1;
            w.write_address = SPECIAL_ADDR0;
            w.write_data    = SPECIAL_DATA0;
            expected_writes.push_back(w);
            w.write_address = SPECIAL_ADDR1;
            w.write_data    = SPECIAL_DATA1;
            expected_writes.push_back(w);
         end
         default: ;
      endcase
   endtask

   task automatic predict_code();
      logic [7:0] ty;
      logic [3:0] nib;
      int         queued_before;
      ty            = req_code_address[31:24];
      nib           = ty[7:4];
      queued_before = expected_writes.size();
      if (req_cheat_enabled) begin
         cheat_was_on[req_cheat_slot] = 1'b1;
         if (!req_action) begin
            if (nib == NIB_BOOT)
               queue_write(ty, req_code_address[23:0], req_code_value, req_mem_data, 1'b1,
                           req_code_slot);
         end else begin
            if (req_first_code)
               skip_next = 1'b0;
            if (nib == NIB_TEST) begin
               if (!req_button_pressed && (ty == TYPE_EQ8_BTN || ty == TYPE_EQ16_BTN ||
                                           ty == TYPE_NE8_BTN || ty == TYPE_NE16_BTN))
                  skip_next = 1'b1;
               if (!test_holds(ty, req_code_value, req_mem_data))
                  skip_next = 1'b1;
            end else if (skip_next) begin
               skip_next = 1'b0;
            end else if (ty == TYPE_W8_BTN || ty == TYPE_W16_BTN ||
                         ty == TYPE_W8_ALTBTN || ty == TYPE_W16_ALTBTN) begin
               if (req_button_pressed)
                  queue_write(ty, req_code_address[23:0], req_code_value, req_mem_data, 1'b0,
                              req_code_slot);
            end else if (nib != NIB_BOOT) begin
               queue_write(ty, req_code_address[23:0], req_code_value, req_mem_data, 1'b1,
                           req_code_slot);
            end
         end
      end else begin
         if (req_first_code) begin
            restoring = cheat_was_on[req_cheat_slot] && req_action;
            cheat_was_on[req_cheat_slot] = 1'b0;
         end
         // write back the saved value, then forget it
         if (restoring && captured[req_code_slot]) begin
            queue_write(ty, req_code_address[23:0], saved_word[req_code_slot], req_mem_data,
                        1'b0, req_code_slot);
            captured[req_code_slot] = 1'b0;
         end
      end
      if (expected_writes.size() > queued_before)
         expected_writes[$].last_result = 1'b1;
   endtask

   task automatic report_field(input string field, input logic [23:0] want,
                               input logic [23:0] got);
      mismatches++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
   endtask

   task automatic check_write();
      result_type want;
      if (expected_writes.size() == 0) begin
         mismatches++;
         $display("%0t: write beat with none expected: expected nothing, got addr %h data %h",
                  $time, rsp_write_address, rsp_write_data);
      end else begin
         want = expected_writes.pop_front();
         if (rsp_write_valid !== want.write_valid)
            report_field("write_valid", 24'(want.write_valid), 24'(rsp_write_valid));
         if (rsp_write_address !== want.write_address)
            report_field("write_address", want.write_address, rsp_write_address);
         if (rsp_write_data !== want.write_data)
            report_field("write_data", 24'(want.write_data), 24'(rsp_write_data));
         if (rsp_write_size !== want.write_size)
            report_field("write_size", 24'(want.write_size), 24'(rsp_write_size));
         if (rsp_last_result !== want.last_result)
            report_field("last_result", 24'(want.last_result), 24'(rsp_last_result));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mismatches = 0;
         skip_next  = 1'b0;
         restoring  = 1'b0;
         for (int i = 0; i < MAX_CHEATS; i++)
            cheat_was_on[i] = 1'b0;
         for (int i = 0; i < MAX_CODES; i++)
            captured[i] = 1'b0;
         expected_writes.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_write();
         if (req_valid && !req_stall)
            predict_code();
      end
      writes_outstanding <= expected_writes.size();
   end

endmodule

@@ test/cheat_code_patch_engine_tb.sv @@
// Testbench top for the cheat code patch engine: stimulus, idling and verdict.
`timescale 1ns / 1ps
module cheat_code_patch_engine_tb;
   import ccpe_pkg::*;

   localparam int   PASS_BOOT  = 0;
   localparam int   PASS_FRAME = 1;
   localparam int   NUM_CHEATS = 6;
   localparam int   MAX_LEN    = 4;
   localparam int   DRAIN_CYCLES   = 8;
   localparam int   WATCHDOG_LIMIT = 3000;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_action;
   logic [CHEAT_W-1:0] req_cheat_slot;
   logic               req_cheat_enabled;
   logic               req_first_code;
   logic [CODE_W-1:0]  req_code_slot;
   logic [31:0]        req_code_address;
   logic [15:0]        req_code_value;
   logic               req_button_pressed;
   logic [15:0]        req_mem_data;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_write_valid;
   logic [23:0]        rsp_write_address;
   logic [15:0]        rsp_write_data;
   logic               rsp_write_size;
   logic               rsp_last_result;
   int                 mismatches;
   int                 writes_outstanding;

   int req_idle_pct;
   int rsp_idle_pct;
   int codes_sent;
   int quiet_cycles;

   // cheat list of the current random session
   int                 ch_slot [NUM_CHEATS];
   int                 ch_on [NUM_CHEATS];
   int                 ch_len [NUM_CHEATS];
   logic [31:0]        ch_word [NUM_CHEATS][MAX_LEN];
   logic [15:0]        ch_value [NUM_CHEATS][MAX_LEN];
   int                 ch_code_slot [NUM_CHEATS][MAX_LEN];

   cheat_code_patch_engine u_dut (.*);

   cheat_code_patch_engine_checker u_checker (.*);

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_code(input int act, input int cheat,
                            input int en, input int first,
                            input int cslot, input logic [31:0] word,
                            input logic [15:0] value, input int btn,
                            input logic [15:0] mem);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= act[0];
      req_cheat_slot     <= cheat[CHEAT_W-1:0];
      req_cheat_enabled  <= en[0];
      req_first_code     <= first[0];
      req_code_slot      <= cslot[CODE_W-1:0];
      req_code_address   <= word;
      req_code_value     <= value;
      req_button_pressed <= btn[0];
      req_mem_data       <= mem;
      // hold the beat until it is taken
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      codes_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (writes_outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_type();
      case ($urandom_range(0, 18))
         0:       return TYPE_W8;
         1:       return TYPE_W8_BTN;
         2:       return TYPE_W8_ALT;
         3:       return TYPE_W8_ALTBTN;
         4:       return TYPE_W8_BOOT;
         5:       return TYPE_W16;
         6:       return TYPE_W16_BTN;
         7:       return TYPE_W16_ALT;
         8:       return TYPE_W16_ALTBTN;
         9:       return TYPE_W16_BOOT;
         10:      return TYPE_EQ8;
         11:      return TYPE_EQ8_BTN;
         12:      return TYPE_EQ16;
         13:      return TYPE_EQ16_BTN;
         14:      return TYPE_NE8;
         15:      return TYPE_NE8_BTN;
         16:      return TYPE_NE16;
         17:      return TYPE_NE16_BTN;
         default: return TYPE_SPECIAL;
      endcase
   endfunction

   function automatic logic [31:0] code_word();
      logic [31:0] r;
      r = $urandom;
      if ($urandom_range(0, 9) == 0)
         return r;
      return {pick_type(), r[23:0]};
   endfunction

   // bias memory toward the operand so that tests often pass as well as fail
   function automatic logic [15:0] memory_word(input logic [15:0] value);
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 3))
         0:       return value;
         1:       return {r[15:8], value[7:0]};
         default: return r[15:0];
      endcase
   endfunction

   task automatic build_cheats();
      for (int c = 0; c < NUM_CHEATS; c++) begin
         ch_slot[c] = $urandom_range(0, MAX_CHEATS - 1);
         ch_on[c]   = ($urandom_range(0, 3) != 0) ? 1 : 0;
         ch_len[c]  = $urandom_range(1, MAX_LEN);
         for (int k = 0; k < MAX_LEN; k++) begin
            ch_word[c][k]      = code_word();
            ch_value[c][k]     = 16'($urandom);
            ch_code_slot[c][k] = $urandom_range(0, MAX_CODES - 1);
         end
      end
   endtask

   task automatic run_pass(input int act);
      int first;
      for (int c = 0; c < NUM_CHEATS; c++) begin
         for (int k = 0; k < ch_len[c]; k++) begin
            if ($urandom_range(0, 99) < 6)
               send_code($urandom_range(0, 1), $urandom_range(0, MAX_CHEATS - 1),
                         $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, MAX_CODES - 1), $urandom, 16'($urandom),
                         $urandom_range(0, 1), 16'($urandom));
            // now and then drop the first marker or put one mid-cheat
            if (k == 0)
               first = ($urandom_range(0, 19) != 0) ? 1 : 0;
            else
               first = ($urandom_range(0, 49) == 0) ? 1 : 0;
            send_code(act, ch_slot[c], ch_on[c], first, ch_code_slot[c][k], ch_word[c][k],
                      ch_value[c][k], $urandom_range(0, 1), memory_word(ch_value[c][k]));
         end
      end
   endtask

   task automatic random_phase(input int goal);
      int start;
      int passes;
      start = codes_sent;
      while (codes_sent - start < goal) begin
         build_cheats();
         run_pass(PASS_BOOT);
         passes = $urandom_range(3, 6);
         for (int p = 0; p < passes; p++) begin
            for (int c = 0; c < NUM_CHEATS; c++)
               if ($urandom_range(0, 99) < 30)
                  ch_on[c] = 1 - ch_on[c];
            run_pass(($urandom_range(0, 9) == 0) ? PASS_BOOT : PASS_FRAME);
         end
         if ($urandom_range(0, 3) == 0)
            drain();
      end
   endtask

   task automatic directed_codes();
      // boot pass: only boot-type codes run, saving the prior value
      send_code(PASS_BOOT, 63, 1, 1, 255, {TYPE_W8_BOOT, 24'hFFFFFF}, 16'hFFFF, 1, 16'hFFFF);
      send_code(PASS_BOOT, 63, 1, 0, 0, {TYPE_W16_BOOT, 24'h000000}, 16'h0000, 0, 16'h1234);
      send_code(PASS_BOOT, 63, 1, 0, 1, {TYPE_W8, 24'h000100}, 16'h00AA, 0, 16'h0000);
      // frame pass writes, plain and button gated
      send_code(PASS_FRAME, 63, 1, 1, 2, {TYPE_W8, 24'h123456}, 16'hABCD, 0, 16'h005A);
      send_code(PASS_FRAME, 63, 1, 0, 3, {TYPE_W16, 24'h800000}, 16'h8001, 0, 16'h7FFE);
      send_code(PASS_FRAME, 63, 1, 0, 4, {TYPE_W8_ALT, 24'h00FF00}, 16'h0080, 0, 16'hFF01);
      send_code(PASS_FRAME, 63, 1, 0, 5, {TYPE_W16_ALT, 24'hFFFFFE}, 16'hFFFF, 0, 16'h0000);
      send_code(PASS_FRAME, 63, 1, 0, 6, {TYPE_W8_BTN, 24'h000010}, 16'h0011, 1, 16'h0022);
      send_code(PASS_FRAME, 63, 1, 0, 7, {TYPE_W16_BTN, 24'h000012}, 16'h3344, 0, 16'h5566);
      send_code(PASS_FRAME, 63, 1, 0, 8, {TYPE_W8_ALTBTN, 24'h000014}, 16'h0099, 1, 16'h0001);
      send_code(PASS_FRAME, 63, 1, 0, 9, {TYPE_W16_ALTBTN, 24'h000016}, 16'hBEEF, 1, 16'h0002);
      // tests: a pass lets the next write run, a failure skips it
      send_code(PASS_FRAME, 63, 1, 0, 10, {TYPE_EQ8, 24'h000020}, 16'h12AB, 0, 16'h34AB);
      send_code(PASS_FRAME, 63, 1, 0, 11, {TYPE_W8, 24'h000022}, 16'h0033, 0, 16'h0044);
      send_code(PASS_FRAME, 63, 1, 0, 12, {TYPE_EQ16, 24'h000024}, 16'h1234, 0, 16'h1235);
      send_code(PASS_FRAME, 63, 1, 0, 13, {TYPE_W16, 24'h000026}, 16'h5555, 0, 16'h6666);
      send_code(PASS_FRAME, 63, 1, 0, 14, {TYPE_EQ8_BTN, 24'h000028}, 16'h0077, 0, 16'h0077);
      send_code(PASS_FRAME, 63, 1, 0, 15, {TYPE_W8, 24'h00002A}, 16'h0088, 0, 16'h0000);
      send_code(PASS_FRAME, 63, 1, 0, 16, {TYPE_EQ16_BTN, 24'h00002C}, 16'hA5A5, 1, 16'hA5A5);
      send_code(PASS_FRAME, 63, 1, 0, 17, {TYPE_NE8_BTN, 24'h00002E}, 16'h0001, 1, 16'h0002);
      send_code(PASS_FRAME, 63, 1, 0, 18, {TYPE_NE16_BTN, 24'h000030}, 16'h0100, 1, 16'h0200);
      send_code(PASS_FRAME, 63, 1, 0, 19, {TYPE_NE8, 24'h000032}, 16'h11CC, 0, 16'h22CC);
      // another test type passes and leaves the failed flag set
      send_code(PASS_FRAME, 63, 1, 0, 20, {8'hDF, 24'h000034}, 16'h0000, 0, 16'hFFFF);
      send_code(PASS_FRAME, 63, 1, 0, 21, {TYPE_SPECIAL, 24'h000036}, 16'h0000, 0, 16'h0000);
      send_code(PASS_FRAME, 63, 1, 0, 22, {TYPE_SPECIAL, 24'hABCDEF}, 16'h1111, 0, 16'h2222);
      send_code(PASS_FRAME, 63, 1, 0, 23, {8'h00, 24'h000038}, 16'h3333, 0, 16'h4444);
      send_code(PASS_FRAME, 63, 1, 0, 24, {TYPE_W16_BOOT, 24'h00003A}, 16'h7777, 0, 16'h8888);
      // a failure at the end of one cheat is cleared by the next first code
      send_code(PASS_FRAME, 0, 1, 1, 25, {TYPE_NE16, 24'h00003C}, 16'h4242, 0, 16'h4242);
      send_code(PASS_FRAME, 0, 1, 1, 26, {TYPE_W16, 24'h00003E}, 16'hCAFE, 0, 16'h0F0F);
      // disabled in a frame pass: write the saved values back
      send_code(PASS_FRAME, 63, 0, 1, 255, {TYPE_W8_BOOT, 24'hFFFFFF}, 16'h0000, 0, 16'h0000);
      send_code(PASS_FRAME, 63, 0, 0, 2, {TYPE_W8, 24'h123456}, 16'hABCD, 0, 16'h00CD);
      send_code(PASS_FRAME, 63, 0, 0, 0, {TYPE_SPECIAL, 24'h000000}, 16'h0000, 0, 16'h0000);
      // disabled in a boot pass: no restore, and the cheat is then forgotten
      send_code(PASS_BOOT, 0, 0, 1, 26, {TYPE_W16, 24'h00003E}, 16'hCAFE, 0, 16'h0000);
      send_code(PASS_FRAME, 0, 0, 1, 26, {TYPE_W16, 24'h00003E}, 16'hCAFE, 0, 16'h0000);
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_action         = 1'b0;
      req_cheat_slot     = '0;
      req_cheat_enabled  = 1'b0;
      req_first_code     = 1'b0;
      req_code_slot      = '0;
      req_code_address   = '0;
      req_code_value     = '0;
      req_button_pressed = 1'b0;
      req_mem_data       = '0;
      codes_sent         = 0;
      req_idle_pct       = 29;
      rsp_idle_pct       = 74;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_codes();
      drain();
      random_phase(140);
      drain();
      req_idle_pct = 74;
      rsp_idle_pct = 29;
      random_phase(140);
      drain();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_phase(140);
      drain();

      if (mismatches == 0 && writes_outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ccpe_pkg.sv
rtl/core/ccpe_saved_store.sv
rtl/core/cheat_code_patch_engine.sv
test/cheat_code_patch_engine_checker.sv
test/cheat_code_patch_engine_tb.sv
